// ===== rtl/morse_key_pulse_transmitter_macros.svh =====
// assertion macros for the morse key pulse transmitter
// expects clk and arst_n in the scope of each use
`ifndef MORSE_KEY_PULSE_TRANSMITTER_MACROS_SVH
`define MORSE_KEY_PULSE_TRANSMITTER_MACROS_SVH

// same-cycle implication
`define MKPT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MKPT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/mkpt_pkg.sv =====
// shared types and constants for the morse key pulse transmitter
// no dependencies
package mkpt_pkg;

	localparam int unsigned MAX_SYMBOLS_DEF = 16;

	localparam int unsigned MS_W       = 32;
	localparam int unsigned WIDTH_W    = 16;
	localparam int unsigned COUNT_W    = 5;
	localparam int unsigned REP_W      = 2;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_SLOT = 1'b1;

	localparam logic [WIDTH_W-1:0] DOT_MAX_MS_RST    = 16'd250;
	localparam logic [WIDTH_W-1:0] IDLE_GAP_MS_RST   = 16'd1000;
	localparam logic [WIDTH_W-1:0] START_WIDTH_RST   = 16'd5000;
	localparam logic [WIDTH_W-1:0] DOT_WIDTH_RST     = 16'd15000;
	localparam logic [WIDTH_W-1:0] DASH_WIDTH_RST    = 16'd20000;
	localparam logic [WIDTH_W-1:0] END_WIDTH_RST     = 16'd10000;
	localparam logic [REP_W-1:0]   START_REPEATS_RST = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DOT_MAX_MS    = 3'd0,
		REG_IDLE_GAP_MS   = 3'd1,
		REG_START_WIDTH   = 3'd2,
		REG_DOT_WIDTH     = 3'd3,
		REG_DASH_WIDTH    = 3'd4,
		REG_END_WIDTH     = 3'd5,
		REG_START_REPEATS = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [WIDTH_W-1:0] dot_max_ms;
		logic [WIDTH_W-1:0] idle_gap_ms;
		logic [WIDTH_W-1:0] start_width;
		logic [WIDTH_W-1:0] dot_width;
		logic [WIDTH_W-1:0] dash_width;
		logic [WIDTH_W-1:0] end_width;
		logic [REP_W-1:0]   start_repeats;
	} cfg_t;

	typedef struct packed {
		logic [WIDTH_W-1:0] pulse_width;
		logic               pulse_valid;
		logic               sending;
		logic [COUNT_W-1:0] queued_symbols;
	} res_t;

endpackage

// ===== rtl/mkpt_if.sv =====
// valid/ready channel interfaces for input and result words
// depends on mkpt_pkg
interface mkpt_in_if import mkpt_pkg::*; ();
	logic valid;
	logic ready;
	logic func;
	logic key_down;

	modport source (output valid, output func, output key_down, input ready);
	modport sink (input valid, input func, input key_down, output ready);
endinterface

interface mkpt_out_if import mkpt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [WIDTH_W-1:0] pulse_width;
	logic               pulse_valid;
	logic               sending;
	logic [COUNT_W-1:0] queued_symbols;

	modport source (output valid, output pulse_width, output pulse_valid,
		output sending, output queued_symbols, input ready);
	modport sink (input valid, input pulse_width, input pulse_valid,
		input sending, input queued_symbols, output ready);
endinterface

// ===== rtl/mkpt_cfg.sv =====
// configuration register file, write only
// depends on mkpt_pkg
module mkpt_cfg import mkpt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dot_max_ms    <= DOT_MAX_MS_RST;
			cfg_q.idle_gap_ms   <= IDLE_GAP_MS_RST;
			cfg_q.start_width   <= START_WIDTH_RST;
			cfg_q.dot_width     <= DOT_WIDTH_RST;
			cfg_q.dash_width    <= DASH_WIDTH_RST;
			cfg_q.end_width     <= END_WIDTH_RST;
			cfg_q.start_repeats <= START_REPEATS_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_DOT_MAX_MS:    cfg_q.dot_max_ms    <= cfg_wdata;
				REG_IDLE_GAP_MS:   cfg_q.idle_gap_ms   <= cfg_wdata;
				REG_START_WIDTH:   cfg_q.start_width   <= cfg_wdata;
				REG_DOT_WIDTH:     cfg_q.dot_width     <= cfg_wdata;
				REG_DASH_WIDTH:    cfg_q.dash_width    <= cfg_wdata;
				REG_END_WIDTH:     cfg_q.end_width     <= cfg_wdata;
				REG_START_REPEATS: cfg_q.start_repeats <= cfg_wdata[REP_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/mkpt_core.sv =====
// key timing, symbol queue and pulse sequencing state with next-state logic
// depends on mkpt_pkg
module mkpt_core import mkpt_pkg::*; #(
	parameter int unsigned MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic func,
	input  logic key_down,
	input  cfg_t cfg,
	output res_t res
);

	localparam int unsigned SYM_W = MAX_SYMBOLS;

	logic [MS_W-1:0]    ms_q, press_q, rel_q;
	logic               held_q, tx_q;
	logic [SYM_W-1:0]   bits_q;
	logic [COUNT_W-1:0] cnt_q, pos_q;
	logic [REP_W-1:0]   starts_q;

	logic [MS_W-1:0]    ms_n, press_n, rel_n;
	logic               held_n, tx_n;
	logic [SYM_W-1:0]   bits_n;
	logic [COUNT_W-1:0] cnt_n, pos_n;
	logic [REP_W-1:0]   starts_n;

	logic [MS_W-1:0]    held_for, idle_for;
	logic [COUNT_W-1:0] diff;
	logic [SYM_W-1:0]   sym;
	logic [WIDTH_W-1:0] width;
	logic               pv;

	always_comb begin
		ms_n     = ms_q;
		press_n  = press_q;
		rel_n    = rel_q;
		held_n   = held_q;
		tx_n     = tx_q;
		bits_n   = bits_q;
		cnt_n    = cnt_q;
		pos_n    = pos_q;
		starts_n = starts_q;
		held_for = '0;
		idle_for = '0;
		diff     = '0;
		sym      = '0;
		width    = '0;
		pv       = 1'b0;
		if (func == FUNC_TICK) begin
			ms_n = ms_q + 1'b1;
			if (key_down && !held_q) begin
				held_n  = 1'b1;
				press_n = ms_n;
			end
			if (!key_down && held_q) begin
				held_n   = 1'b0;
				rel_n    = ms_n;
				held_for = ms_n - press_q;
				if (cnt_q < COUNT_W'(MAX_SYMBOLS)) begin
					bits_n = (bits_q << 1)
						| SYM_W'(held_for > MS_W'(cfg.dot_max_ms));
					cnt_n  = cnt_q + 1'b1;
				end
			end
			idle_for = ms_n - rel_n;
			if ((cnt_n != '0) && !tx_q && (idle_for >= MS_W'(cfg.idle_gap_ms))) begin
				tx_n  = 1'b1;
				pos_n = '0;
			end
		end else if (tx_q) begin
			pv   = 1'b1;
			diff = cnt_q - pos_q - 1'b1;
			sym  = bits_q >> diff;
			if ((pos_q == '0) && (starts_q < cfg.start_repeats)) begin
				width    = cfg.start_width;
				starts_n = starts_q + 1'b1;
			end else if (pos_q < cnt_q) begin
				width = sym[0] ? cfg.dash_width : cfg.dot_width;
				pos_n = pos_q + 1'b1;
			end else if (pos_q == cnt_q) begin
				width = cfg.end_width;
				pos_n = pos_q + 1'b1;
			end else begin
				tx_n     = 1'b0;
				bits_n   = '0;
				cnt_n    = '0;
				starts_n = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q     <= '0;
			press_q  <= '0;
			rel_q    <= '0;
			held_q   <= 1'b0;
			tx_q     <= 1'b0;
			bits_q   <= '0;
			cnt_q    <= '0;
			pos_q    <= '0;
			starts_q <= '0;
		end else if (en) begin
			ms_q     <= ms_n;
			press_q  <= press_n;
			rel_q    <= rel_n;
			held_q   <= held_n;
			tx_q     <= tx_n;
			bits_q   <= bits_n;
			cnt_q    <= cnt_n;
			pos_q    <= pos_n;
			starts_q <= starts_n;
		end
	end

	always_comb begin
		res.pulse_width    = width;
		res.pulse_valid    = pv;
		res.sending        = tx_n;
		res.queued_symbols = cnt_n;
	end

endmodule

// ===== rtl/morse_key_pulse_transmitter.sv =====
// morse key pulse transmitter top level
// input word: func selects a millisecond tick carrying key_down (0) or a
// pulse slot request (1); every input word yields exactly one result word
// carrying pulse_width, pulse_valid, sending and queued_symbols
// configuration: cfg_we/cfg_index/cfg_wdata write the timing, width and repeat
// registers; the user must write only while no word is in flight, not enforced
// an accepted word is registered in the input stage and processed there by the
// core; its result is registered in the output register when the stage advances
// throughput is one word per cycle while out_ch is not stalled; the state update
// in the core (32-bit ms increment and subtract-compare) sets the clock rate
// when the receiver stalls, the result stays in the output register, the
// input stage holds one more word and in_ch.ready drops until out_ch drains
// reset clears the pipeline, the key timer, the symbol queue and the sender,
// and loads the configuration registers with their default values
// depends on mkpt_pkg, mkpt_if, mkpt_cfg, mkpt_core and the macro header
`include "morse_key_pulse_transmitter_macros.svh"

module morse_key_pulse_transmitter import mkpt_pkg::*; #(
	parameter int unsigned MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	mkpt_in_if.sink               in_ch,
	mkpt_out_if.source            out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t cfg;
	res_t res;
	res_t res_q;
	logic valid_s1, func_s1, key_s1;
	logic out_valid_q;
	logic adv;

	mkpt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	mkpt_core #(
		.MAX_SYMBOLS (MAX_SYMBOLS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.func     (func_s1),
		.key_down (key_s1),
		.cfg      (cfg),
		.res      (res)
	);

	assign adv         = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			func_s1 <= in_ch.func;
			key_s1  <= in_ch.key_down;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.pulse_width    = res_q.pulse_width;
	assign out_ch.pulse_valid    = res_q.pulse_valid;
	assign out_ch.sending        = res_q.sending;
	assign out_ch.queued_symbols = res_q.queued_symbols;

	`MKPT_ASSERT_NOW(a_queue_bound, out_valid_q, res_q.queued_symbols <= COUNT_W'(MAX_SYMBOLS), "queue count over limit")
	`MKPT_ASSERT_NOW(a_width_unserved, out_valid_q && !res_q.pulse_valid, res_q.pulse_width == '0, "width on unserved word")
	`MKPT_ASSERT_NOW(a_end_width_zero, out_valid_q && res_q.pulse_valid && !res_q.sending, res_q.pulse_width == '0, "ending slot with nonzero width")
	`MKPT_ASSERT_NEXT(a_stage_held, valid_s1 && !adv, valid_s1, "input stage lost a word")

endmodule
